[hdl/prac_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prac_pkg: shared constants for the point rotation core
// Holds the default sizes, the angle folding constants, the CORDIC gain
// and the arctangent table used by the rotation stages.
// ----------------------------------------------------------------------------
package prac_pkg;

   // Default sizes, handed to the top level as parameter defaults.
   localparam int COORD_BITS_DEFAULT    = 24;
   localparam int CORDIC_STAGES_DEFAULT = 16;

   // Angle input: signed, 1/128 degree per LSB.
   localparam int ANGLE_BITS = 17;
   // Working width for the folded angle, wide enough for two full turns.
   localparam int FOLD_BITS  = ANGLE_BITS + 1;
   localparam logic signed [FOLD_BITS-1:0] FULL_TURN    = 18'sd46080;
   localparam logic signed [FOLD_BITS-1:0] TWO_TURNS    = 18'sd92160;
   localparam logic [15:0]                 QUARTER_TURN = 16'd11520;
   localparam logic [15:0]                 HALF_TURN    = 16'd23040;
   localparam logic [15:0]                 THREE_QUARTERS = 16'd34560;

   // Residual angle inside one quadrant, and its scale up to 2^-20 degree.
   localparam int REM_BITS   = 14;
   localparam int ANGLE_UP_SHIFT = 13;
   localparam int Z_BITS     = 29;

   // Quadrant codes.
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // CORDIC gain correction K in Q30, held as a positive signed constant.
   localparam int GAIN_BITS = 32;
   localparam logic signed [GAIN_BITS-1:0] GAIN_Q30 = 32'sd652032874;
   localparam int GAIN_FRAC_SHIFT = 22;

   // Extra bits above the coordinate width for the rotating vector
   // (8 guard fraction bits plus growth and sign).
   localparam int X_GROWTH   = 10;
   localparam int GUARD_BITS = 8;

   // Number of arctangent entries available.
   localparam int ATAN_LEN = 24;
   localparam int ATAN_IDX_BITS = 5;

   // Arctangent of 2^-i in degrees, scaled by 2^20.
   function automatic logic signed [Z_BITS-1:0] atan_q20(input logic [ATAN_IDX_BITS-1:0] idx);
      logic signed [Z_BITS-1:0] val;
      unique case (idx)
         5'd0:    val = 29'sd47185920;
         5'd1:    val = 29'sd27855475;
         5'd2:    val = 29'sd14718068;
         5'd3:    val = 29'sd7471121;
         5'd4:    val = 29'sd3750058;
         5'd5:    val = 29'sd1876857;
         5'd6:    val = 29'sd938658;
         5'd7:    val = 29'sd469357;
         5'd8:    val = 29'sd234682;
         5'd9:    val = 29'sd117342;
         5'd10:   val = 29'sd58671;
         5'd11:   val = 29'sd29335;
         5'd12:   val = 29'sd14668;
         5'd13:   val = 29'sd7334;
         5'd14:   val = 29'sd3667;
         5'd15:   val = 29'sd1833;
         5'd16:   val = 29'sd917;
         5'd17:   val = 29'sd458;
         5'd18:   val = 29'sd229;
         5'd19:   val = 29'sd115;
         5'd20:   val = 29'sd57;
         5'd21:   val = 29'sd29;
         5'd22:   val = 29'sd14;
         5'd23:   val = 29'sd7;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

[hdl/point_rotation_about_center_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// point_rotation_about_center_core: rotate a point about a center
// Counter-clockwise rotation by an angle in 1/128 degree, using exact
// quarter turns and a fully pipelined CORDIC for the residual angle.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake            Contents
//   req_      in         req_valid/req_ready  center, point, turn angle
//   rsp_      out        rsp_valid/rsp_ready  rotated point, saturated
//
// One transaction enters per clock unless rsp_ready holds the pipeline, which
// has three front-end stages, one per CORDIC iteration and one output stage.
// Every stage has its own valid bit and takes new data when empty or when
// the next stage moves, so bubbles close up under a stall and nothing is
// dropped or duplicated. Synchronous reset clears only the valid bits.
// ----------------------------------------------------------------------------
module point_rotation_about_center_core #(
   parameter int COORD_BITS    = prac_pkg::COORD_BITS_DEFAULT,
   parameter int CORDIC_STAGES = prac_pkg::CORDIC_STAGES_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  wire  signed [COORD_BITS-1:0]           req_center_x,
   input  wire  signed [COORD_BITS-1:0]           req_center_y,
   input  wire  signed [COORD_BITS-1:0]           req_point_x,
   input  wire  signed [COORD_BITS-1:0]           req_point_y,
   input  wire  signed [prac_pkg::ANGLE_BITS-1:0] req_turn_angle,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic signed [COORD_BITS-1:0]           rsp_rotated_x,
   output logic signed [COORD_BITS-1:0]           rsp_rotated_y
);

   localparam int XW = COORD_BITS + prac_pkg::X_GROWTH;
   localparam int ZW = prac_pkg::Z_BITS;
   localparam int NS = (CORDIC_STAGES > prac_pkg::ATAN_LEN) ?
                       prac_pkg::ATAN_LEN : CORDIC_STAGES;

   // Links between pipeline sections; index k feeds CORDIC stage k.
   logic [NS:0]                  lk_valid;
   logic [NS:0]                  lk_ready;
   logic signed [XW-1:0]         lk_x  [0:NS];
   logic signed [XW-1:0]         lk_y  [0:NS];
   logic signed [ZW-1:0]         lk_z  [0:NS];
   logic signed [COORD_BITS-1:0] lk_cx [0:NS];
   logic signed [COORD_BITS-1:0] lk_cy [0:NS];

   // Front end: offsets, gain multiply, quadrant rotation.
   prac_prep #(
      .COORD_BITS (COORD_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_cx     (req_center_x),
      .in_cy     (req_center_y),
      .in_px     (req_point_x),
      .in_py     (req_point_y),
      .in_angle  (req_turn_angle),
      .out_valid (lk_valid[0]),
      .out_ready (lk_ready[0]),
      .out_x     (lk_x[0]),
      .out_y     (lk_y[0]),
      .out_z     (lk_z[0]),
      .out_cx    (lk_cx[0]),
      .out_cy    (lk_cy[0])
   );

   // One registered micro-rotation per CORDIC iteration.
   for (genvar g = 0; g < NS; g++) begin : g_cordic
      prac_cordic_stage #(
         .COORD_BITS (COORD_BITS),
         .STAGE_IDX  (g)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (lk_valid[g]),
         .in_ready  (lk_ready[g]),
         .in_x      (lk_x[g]),
         .in_y      (lk_y[g]),
         .in_z      (lk_z[g]),
         .in_cx     (lk_cx[g]),
         .in_cy     (lk_cy[g]),
         .out_valid (lk_valid[g+1]),
         .out_ready (lk_ready[g+1]),
         .out_x     (lk_x[g+1]),
         .out_y     (lk_y[g+1]),
         .out_z     (lk_z[g+1]),
         .out_cx    (lk_cx[g+1]),
         .out_cy    (lk_cy[g+1])
      );
   end

   // Output: rounding, center add-back and saturation.
   prac_post #(
      .COORD_BITS (COORD_BITS)
   ) u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lk_valid[NS]),
      .in_ready  (lk_ready[NS]),
      .in_x      (lk_x[NS]),
      .in_y      (lk_y[NS]),
      .in_cx     (lk_cx[NS]),
      .in_cy     (lk_cy[NS]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_x     (rsp_rotated_x),
      .out_y     (rsp_rotated_y)
   );

endmodule
`default_nettype wire

[hdl/prac_prep.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prac_prep: front end of the rotation pipeline
// Three register stages: differences and angle folding, gain multiply,
// then rounding to 8 guard bits and the exact quarter-turn rotation.
// ----------------------------------------------------------------------------
module prac_prep #(
   parameter int COORD_BITS = prac_pkg::COORD_BITS_DEFAULT
) (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        in_valid,
   output logic                                       in_ready,
   input  wire  signed [COORD_BITS-1:0]               in_cx,
   input  wire  signed [COORD_BITS-1:0]               in_cy,
   input  wire  signed [COORD_BITS-1:0]               in_px,
   input  wire  signed [COORD_BITS-1:0]               in_py,
   input  wire  signed [prac_pkg::ANGLE_BITS-1:0]     in_angle,
   output logic                                       out_valid,
   input  wire                                        out_ready,
   output logic signed [COORD_BITS+prac_pkg::X_GROWTH-1:0] out_x,
   output logic signed [COORD_BITS+prac_pkg::X_GROWTH-1:0] out_y,
   output logic signed [prac_pkg::Z_BITS-1:0]         out_z,
   output logic signed [COORD_BITS-1:0]               out_cx,
   output logic signed [COORD_BITS-1:0]               out_cy
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = DW + prac_pkg::GAIN_BITS;
   localparam int XW = COORD_BITS + prac_pkg::X_GROWTH;
   localparam int RW = prac_pkg::REM_BITS;
   localparam int ZW = prac_pkg::Z_BITS;
   localparam int FW = prac_pkg::FOLD_BITS;

   // Stage handshake: a stage takes new data when empty or draining.
   logic s1_ready, s2_ready, s3_ready;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage 1: offsets from the center and the angle folded into a quadrant.
   logic signed [DW-1:0] s1_dx_in, s1_dy_in, s1_dx_ff, s1_dy_ff;
   logic signed [COORD_BITS-1:0] s1_cx_ff, s1_cy_ff;
   logic [1:0]    s1_quad_in, s1_quad_ff;
   logic [RW-1:0] s1_rem_in, s1_rem_ff;
   logic signed [FW-1:0] ang_ext, ang_plus, ang_plus2;
   logic [15:0] ang_fold;

   always_comb begin
      s1_dx_in  = DW'(in_px) - DW'(in_cx);
      s1_dy_in  = DW'(in_py) - DW'(in_cy);
      ang_ext   = FW'(in_angle);
      ang_plus  = ang_ext + prac_pkg::FULL_TURN;
      ang_plus2 = ang_ext + prac_pkg::TWO_TURNS;
      // Reduce any 17-bit angle into one full turn.
      priority if (ang_plus < 0) begin
         ang_fold = 16'(ang_plus2);
      end else if (ang_ext < 0) begin
         ang_fold = 16'(ang_plus);
      end else if (ang_ext >= prac_pkg::FULL_TURN) begin
         ang_fold = 16'(ang_ext - prac_pkg::FULL_TURN);
      end else begin
         ang_fold = 16'(ang_ext);
      end
      // Split the folded angle into a quarter count and a residual.
      priority if (ang_fold >= prac_pkg::THREE_QUARTERS) begin
         s1_quad_in = prac_pkg::QUAD_3;
         s1_rem_in  = RW'(ang_fold - prac_pkg::THREE_QUARTERS);
      end else if (ang_fold >= prac_pkg::HALF_TURN) begin
         s1_quad_in = prac_pkg::QUAD_2;
         s1_rem_in  = RW'(ang_fold - prac_pkg::HALF_TURN);
      end else if (ang_fold >= prac_pkg::QUARTER_TURN) begin
         s1_quad_in = prac_pkg::QUAD_1;
         s1_rem_in  = RW'(ang_fold - prac_pkg::QUARTER_TURN);
      end else begin
         s1_quad_in = prac_pkg::QUAD_0;
         s1_rem_in  = RW'(ang_fold);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
         s1_cx_ff   <= in_cx;
         s1_cy_ff   <= in_cy;
         s1_quad_ff <= s1_quad_in;
         s1_rem_ff  <= s1_rem_in;
      end
   end

   // Stage 2: gain correction multiply on both offsets.
   logic signed [PW-1:0] s2_px_in, s2_py_in, s2_px_ff, s2_py_ff;
   logic signed [COORD_BITS-1:0] s2_cx_ff, s2_cy_ff;
   logic [1:0]    s2_quad_ff;
   logic [RW-1:0] s2_rem_ff;

   assign s2_px_in = PW'(s1_dx_ff) * PW'(prac_pkg::GAIN_Q30);
   assign s2_py_in = PW'(s1_dy_ff) * PW'(prac_pkg::GAIN_Q30);

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_px_ff   <= s2_px_in;
         s2_py_ff   <= s2_py_in;
         s2_cx_ff   <= s1_cx_ff;
         s2_cy_ff   <= s1_cy_ff;
         s2_quad_ff <= s1_quad_ff;
         s2_rem_ff  <= s1_rem_ff;
      end
   end

   // Stage 3: round half up to the guard bits, then apply the quarter turns.
   logic signed [PW-1:0] px_rnd, py_rnd;
   logic signed [XW-1:0] gx, gy;
   logic signed [XW-1:0] s3_x_in, s3_y_in, s3_x_ff, s3_y_ff;
   logic signed [ZW-1:0] s3_z_in, s3_z_ff;
   logic signed [COORD_BITS-1:0] s3_cx_ff, s3_cy_ff;

   always_comb begin
      px_rnd = s2_px_ff + (PW'(1) <<< (prac_pkg::GAIN_FRAC_SHIFT - 1));
      py_rnd = s2_py_ff + (PW'(1) <<< (prac_pkg::GAIN_FRAC_SHIFT - 1));
      gx     = XW'(px_rnd >>> prac_pkg::GAIN_FRAC_SHIFT);
      gy     = XW'(py_rnd >>> prac_pkg::GAIN_FRAC_SHIFT);
      unique case (s2_quad_ff)
         prac_pkg::QUAD_1: begin
            s3_x_in = -gy;
            s3_y_in = gx;
         end
         prac_pkg::QUAD_2: begin
            s3_x_in = -gx;
            s3_y_in = -gy;
         end
         prac_pkg::QUAD_3: begin
            s3_x_in = gy;
            s3_y_in = -gx;
         end
         default: begin
            s3_x_in = gx;
            s3_y_in = gy;
         end
      endcase
      s3_z_in = ZW'(s2_rem_ff) <<< prac_pkg::ANGLE_UP_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_x_ff  <= s3_x_in;
         s3_y_ff  <= s3_y_in;
         s3_z_ff  <= s3_z_in;
         s3_cx_ff <= s2_cx_ff;
         s3_cy_ff <= s2_cy_ff;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_x     = s3_x_ff;
   assign out_y     = s3_y_ff;
   assign out_z     = s3_z_ff;
   assign out_cx    = s3_cx_ff;
   assign out_cy    = s3_cy_ff;

endmodule
`default_nettype wire

[hdl/prac_cordic_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prac_cordic_stage: one registered CORDIC micro-rotation
// Rotates the vector by plus or minus atan(2^-i) according to the sign of
// the remaining angle, with shifts that round toward minus infinity.
// ----------------------------------------------------------------------------
module prac_cordic_stage #(
   parameter int COORD_BITS = prac_pkg::COORD_BITS_DEFAULT,
   parameter int STAGE_IDX  = 0
) (
   input  wire                                             clock,
   input  wire                                             reset,
   input  wire                                             in_valid,
   output logic                                            in_ready,
   input  wire  signed [COORD_BITS+prac_pkg::X_GROWTH-1:0] in_x,
   input  wire  signed [COORD_BITS+prac_pkg::X_GROWTH-1:0] in_y,
   input  wire  signed [prac_pkg::Z_BITS-1:0]              in_z,
   input  wire  signed [COORD_BITS-1:0]                    in_cx,
   input  wire  signed [COORD_BITS-1:0]                    in_cy,
   output logic                                            out_valid,
   input  wire                                             out_ready,
   output logic signed [COORD_BITS+prac_pkg::X_GROWTH-1:0] out_x,
   output logic signed [COORD_BITS+prac_pkg::X_GROWTH-1:0] out_y,
   output logic signed [prac_pkg::Z_BITS-1:0]              out_z,
   output logic signed [COORD_BITS-1:0]                    out_cx,
   output logic signed [COORD_BITS-1:0]                    out_cy
);

   localparam int XW = COORD_BITS + prac_pkg::X_GROWTH;
   localparam int ZW = prac_pkg::Z_BITS;
   localparam int IW = prac_pkg::ATAN_IDX_BITS;
   localparam logic signed [ZW-1:0] ATAN_STEP = prac_pkg::atan_q20(IW'(STAGE_IDX));

   logic valid_ff;
   logic signed [XW-1:0] xs, ys, x_in, y_in, x_ff, y_ff;
   logic signed [ZW-1:0] z_in, z_ff;
   logic signed [COORD_BITS-1:0] cx_ff, cy_ff;

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // A zero remaining angle counts as positive.
   always_comb begin
      xs = in_x >>> STAGE_IDX;
      ys = in_y >>> STAGE_IDX;
      if (!in_z[ZW-1]) begin
         x_in = in_x - ys;
         y_in = in_y + xs;
         z_in = in_z - ATAN_STEP;
      end else begin
         x_in = in_x + ys;
         y_in = in_y - xs;
         z_in = in_z + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         z_ff  <= z_in;
         cx_ff <= in_cx;
         cy_ff <= in_cy;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_cx    = cx_ff;
   assign out_cy    = cy_ff;

endmodule
`default_nettype wire

[hdl/prac_post.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prac_post: output stage of the rotation pipeline
// Drops the guard bits with round half up, adds the center back and
// saturates to the coordinate range into the result register.
// ----------------------------------------------------------------------------
module prac_post #(
   parameter int COORD_BITS = prac_pkg::COORD_BITS_DEFAULT
) (
   input  wire                                             clock,
   input  wire                                             reset,
   input  wire                                             in_valid,
   output logic                                            in_ready,
   input  wire  signed [COORD_BITS+prac_pkg::X_GROWTH-1:0] in_x,
   input  wire  signed [COORD_BITS+prac_pkg::X_GROWTH-1:0] in_y,
   input  wire  signed [COORD_BITS-1:0]                    in_cx,
   input  wire  signed [COORD_BITS-1:0]                    in_cy,
   output logic                                            out_valid,
   input  wire                                             out_ready,
   output logic signed [COORD_BITS-1:0]                    out_x,
   output logic signed [COORD_BITS-1:0]                    out_y
);

   localparam int XW = COORD_BITS + prac_pkg::X_GROWTH;
   localparam int GB = prac_pkg::GUARD_BITS;
   localparam int SW = XW - GB + 1;

   logic valid_ff;
   logic signed [XW-1:0] x_rnd, y_rnd;
   logic signed [SW-1:0] x_sum, y_sum;
   logic signed [COORD_BITS-1:0] x_in, y_in, x_ff, y_ff;

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Saturate: the sum fits when every bit above the coordinate sign matches it.
   function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SW-1:0] v);
      logic signed [COORD_BITS-1:0] r;
      if (v[SW-1:COORD_BITS-1] == '0 || v[SW-1:COORD_BITS-1] == '1) begin
         r = v[COORD_BITS-1:0];
      end else if (v[SW-1]) begin
         r = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   always_comb begin
      x_rnd = in_x + (XW'(1) <<< (GB - 1));
      y_rnd = in_y + (XW'(1) <<< (GB - 1));
      x_sum = SW'(x_rnd >>> GB) + SW'(in_cx);
      y_sum = SW'(y_rnd >>> GB) + SW'(in_cy);
      x_in  = sat(x_sum);
      y_in  = sat(y_sum);
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;

endmodule
`default_nettype wire
